[hdl/sliding_window_median_filter_unit_defines.svh]
// Assertion helpers shared by the filter modules.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SWMF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/swmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package swmf_pkg;

    // Default sizes
    localparam int MAX_WINDOW_DEF   = 63;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register widths and reset values
    localparam int WS_W = 6;
    localparam int BL_W = 16;
    localparam logic [WS_W-1:0] WS_RESET = 6'd1;
    localparam logic [BL_W-1:0] BL_RESET = 16'd1024;

    // Register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd1;

    // Queue depths
    localparam int JQ_DEPTH = 4;
    localparam int RQ_DEPTH = 4;

    // Per-job control flags passed from front to back
    typedef struct packed {
        logic first;   // first sample of a block: window starts from zeros
        logic emit;    // this job yields a result
        logic last;    // this result closes the block
    } swmf_ctl_t;

endpackage
`default_nettype wire

[hdl/sliding_window_median_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Running median over blocks of signed samples. One sample is taken per clock
// while full is low; the front latches the window at each block start and turns
// the last sample of a block into window/2 extra zero-fill jobs, so input is held
// off while those jobs are queued. The back keeps the window as a row of sorted
// cells updated once per job, then picks the middle cells from those registers the
// next cycle and writes the result into the result queue; a job is taken only while
// its result has a slot in that queue, so results wait while the result side stalls. Configuration
// writes are always ready and the window size takes effect at the next block.
// No clearing pass is needed after reset.
`include "sliding_window_median_filter_unit_defines.svh"
module sliding_window_median_filter_unit
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [BL_W-1:0]         cfg_data,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    output logic                         empty,
    input  wire logic                    pop,
    output logic      [SAMPLE_WIDTH-1:0] median_value,
    output logic                         block_end
);

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int JW = SAMPLE_WIDTH + WW + $bits(swmf_ctl_t);
    localparam int RW = SAMPLE_WIDTH + 1;

    logic          jq_push, jq_full, jq_empty, jq_pop;
    logic [JW-1:0] jq_wdata, jq_rdata;
    logic [$clog2(JQ_DEPTH+1)-1:0] jq_count;
    logic          rq_push, rq_full;
    logic [RW-1:0] rq_wdata, rq_rdata;
    logic [$clog2(RQ_DEPTH+1)-1:0] rq_count;

    assign cfg_ready = 1'b1;

    swmf_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WW           (WW),
        .JW           (JW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .full      (full),
        .jq_push   (jq_push),
        .jq_data   (jq_wdata),
        .jq_full   (jq_full)
    );

    swmf_fifo #(
        .WIDTH (JW),
        .DEPTH (JQ_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (jq_push),
        .wr_data (jq_wdata),
        .rd_en   (jq_pop),
        .rd_data (jq_rdata),
        .full    (jq_full),
        .empty   (jq_empty),
        .count   (jq_count)
    );

    swmf_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WW           (WW),
        .JW           (JW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .jq_empty (jq_empty),
        .jq_data  (jq_rdata),
        .jq_pop   (jq_pop),
        .rq_count (rq_count),
        .rq_push  (rq_push),
        .rq_data  (rq_wdata)
    );

    swmf_fifo #(
        .WIDTH (RW),
        .DEPTH (RQ_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (rq_wdata),
        .rd_en   (pop),
        .rd_data (rq_rdata),
        .full    (rq_full),
        .empty   (empty),
        .count   (rq_count)
    );

    assign median_value = rq_rdata[SAMPLE_WIDTH-1:0];
    assign block_end    = rq_rdata[SAMPLE_WIDTH];

    `SWMF_ASSERT_IMPL(a_rq_no_overflow, rq_push, !rq_full, "result queue overflow")
    `SWMF_ASSERT_IMPL(a_jq_count_bound, jq_pop, jq_count != '0, "job pop from empty queue")

endmodule
`default_nettype wire

[hdl/swmf_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module swmf_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[hdl/swmf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_filter_unit_defines.svh"
module swmf_front
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int WW           = $clog2(MAX_WINDOW + 1),
    parameter int JW           = SAMPLE_WIDTH + WW + $bits(swmf_ctl_t)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [BL_W-1:0]         cfg_data,
    input  wire logic                    push,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    output logic                         full,
    output logic                         jq_push,
    output logic      [JW-1:0]           jq_data,
    input  wire logic                    jq_full
);

    logic [WS_W-1:0] ws_reg;
    logic [BL_W-1:0] bl_reg;
    logic [BL_W-1:0] k_reg, k_next;
    logic [WW-1:0]   win_reg, win_next;
    logic            flush_reg, flush_next;
    logic [WW-1:0]   fj_reg, fj_next;
    logic [BL_W-1:0] fk_reg, fk_next;

    logic [BL_W-1:0] len;
    logic [BL_W-1:0] ws_ext;
    logic            ws_ok;
    logic [WW-1:0]   win_now, half_now, half_cur;
    logic            last_now, emit_now, accept;
    swmf_ctl_t       ctl;
    logic [SAMPLE_WIDTH-1:0] value;

    // Configuration registers, always ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_RESET;
            bl_reg <= BL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:  ws_reg <= cfg_data[WS_W-1:0];
                CFG_BLOCK_LENGTH: bl_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Classify the incoming sample
    assign len      = (bl_reg == '0) ? BL_W'(1) : bl_reg;
    assign ws_ext   = BL_W'(ws_reg);
    assign ws_ok    = (ws_reg != '0) && (ws_ext <= len) && (ws_ext <= BL_W'(MAX_WINDOW));
    assign win_now  = (k_reg != '0) ? win_reg : (ws_ok ? WW'(ws_reg) : WW'(1));
    assign half_now = win_now >> 1;
    assign half_cur = win_reg >> 1;
    assign last_now = ({1'b0, k_reg} + 17'd1) >= {1'b0, len};
    assign emit_now = k_reg >= BL_W'(half_now);
    assign full     = jq_full || flush_reg;
    assign accept   = push && !full;

    // Job build: a flush job shifts in a zero
    always_comb
    begin
        if (flush_reg)
        begin
            ctl.first = 1'b0;
            ctl.emit  = ({1'b0, fk_reg} + 17'(fj_reg)) >= 17'(half_cur);
            ctl.last  = (fj_reg == half_cur);
            value     = '0;
            jq_data   = {ctl, win_reg, value};
            jq_push   = !jq_full;
        end
        else
        begin
            ctl.first = (k_reg == '0);
            ctl.emit  = emit_now;
            ctl.last  = last_now && (half_now == '0);
            value     = sample;
            jq_data   = {ctl, win_now, value};
            jq_push   = accept;
        end
    end

    // Block position and tail flush sequencing
    always_comb
    begin
        k_next     = k_reg;
        win_next   = win_reg;
        flush_next = flush_reg;
        fj_next    = fj_reg;
        fk_next    = fk_reg;
        if (accept)
        begin
            win_next = win_now;
            k_next   = last_now ? '0 : k_reg + BL_W'(1);
            if (last_now && (half_now != '0))
            begin
                flush_next = 1'b1;
                fj_next    = WW'(1);
                fk_next    = k_reg;
            end
        end
        else if (flush_reg && !jq_full)
        begin
            if (fj_reg == half_cur)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                fj_next = fj_reg + WW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            win_reg   <= WW'(1);
            flush_reg <= 1'b0;
            fj_reg    <= '0;
            fk_reg    <= '0;
        end
        else
        begin
            k_reg     <= k_next;
            win_reg   <= win_next;
            flush_reg <= flush_next;
            fj_reg    <= fj_next;
            fk_reg    <= fk_next;
        end
    end

    `SWMF_ASSERT_IMPL(a_flush_blocks_input, flush_reg, full, "input open during flush")
    `SWMF_ASSERT_NEXT(a_flush_starts, accept && last_now && (half_now != '0), flush_reg,
                      "tail flush did not start")
    `SWMF_ASSERT_IMPL(a_jq_no_overflow, jq_push, !jq_full, "job queue overflow")

endmodule
`default_nettype wire

[hdl/swmf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module swmf_back
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int WW           = $clog2(MAX_WINDOW + 1),
    parameter int JW           = SAMPLE_WIDTH + WW + $bits(swmf_ctl_t)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          jq_empty,
    input  wire logic [JW-1:0]                 jq_data,
    output logic                               jq_pop,
    input  wire logic [$clog2(RQ_DEPTH+1)-1:0] rq_count,
    output logic                               rq_push,
    output logic      [SAMPLE_WIDTH:0]         rq_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = SAMPLE_WIDTH;

    // Sorted cells: value and age per cell
    logic signed [SW-1:0] v_reg   [MAX_WINDOW];
    logic        [AW-1:0] age_reg [MAX_WINDOW];
    logic        [WW-1:0] win_reg;
    logic                 pend_reg, pend_last_reg;

    logic signed [SW-1:0] x;
    logic        [WW-1:0] win, wm1;
    swmf_ctl_t            ctl;

    logic signed [SW-1:0] cur_v  [MAX_WINDOW];
    logic        [AW-1:0] cur_a  [MAX_WINDOW];
    logic signed [SW-1:0] lp_v   [MAX_WINDOW];
    logic        [AW-1:0] lp_a   [MAX_WINDOW];
    logic signed [SW-1:0] new_v  [MAX_WINDOW];
    logic        [AW-1:0] new_a  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] del, at_or_after, lp_inf, gt;

    assign x   = jq_data[SW-1:0];
    assign win = jq_data[SW+WW-1:SW];
    assign ctl = jq_data[JW-1:SW+WW];
    assign wm1 = win - WW'(1);

    // Take a job only if its result has a slot waiting
    assign jq_pop = !jq_empty && ((int'(rq_count) + int'(pend_reg)) < RQ_DEPTH);

    // Current window, or all zeros at a block start
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cur_v[i] = ctl.first ? '0 : v_reg[i];
            cur_a[i] = ctl.first ? AW'(i) : age_reg[i];
            del[i]   = (i < int'(win)) && (cur_a[i] == wm1[AW-1:0]);
        end
    end

    // Mark cells at or past the one that drops out
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            at_or_after[i] = 1'b0;
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                if (j <= i)
                begin
                    at_or_after[i] = at_or_after[i] | del[j];
                end
            end
        end
    end

    // Window with the oldest removed; missing tail reads as +inf
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (!at_or_after[i])
            begin
                lp_v[i]   = cur_v[i];
                lp_a[i]   = cur_a[i];
                lp_inf[i] = (i >= int'(win));
            end
            else if (i + 1 < MAX_WINDOW)
            begin
                lp_v[i]   = cur_v[(i + 1) % MAX_WINDOW];
                lp_a[i]   = cur_a[(i + 1) % MAX_WINDOW];
                lp_inf[i] = (i + 1 >= int'(win));
            end
            else
            begin
                lp_v[i]   = '0;
                lp_a[i]   = '0;
                lp_inf[i] = 1'b1;
            end
            gt[i] = lp_inf[i] || (lp_v[i] > x);
        end
    end

    // Insert the new sample in sorted place
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (!gt[i])
            begin
                new_v[i] = lp_v[i];
                new_a[i] = lp_a[i] + AW'(1);
            end
            else if ((i > 0) && gt[(i + MAX_WINDOW - 1) % MAX_WINDOW])
            begin
                new_v[i] = lp_v[(i + MAX_WINDOW - 1) % MAX_WINDOW];
                new_a[i] = lp_a[(i + MAX_WINDOW - 1) % MAX_WINDOW] + AW'(1);
            end
            else
            begin
                new_v[i] = x;
                new_a[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_pop)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                v_reg[i]   <= new_v[i];
                age_reg[i] <= new_a[i];
            end
            win_reg       <= win;
            pend_last_reg <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= jq_pop && ctl.emit;
        end
    end

    // Median of the updated window
    logic [WW-1:0]        half_w;
    logic [AW-1:0]        mid, midl;
    logic signed [SW-1:0] vm, vl;
    logic signed [SW:0]   sum;
    logic signed [SW-1:0] med;

    always_comb
    begin
        half_w = win_reg >> 1;
        mid    = half_w[AW-1:0];
        // lower middle cell; a one-sample window keeps cell 0 in range
        midl   = (mid == '0) ? mid : mid - AW'(1);
        vm     = v_reg[mid];
        vl     = v_reg[midl];
        sum    = {vm[SW-1], vm} + {vl[SW-1], vl};
        med    = win_reg[0] ? vm : sum[SW:1];
    end

    assign rq_push = pend_reg;
    assign rq_data = {pend_last_reg, med};

endmodule
`default_nettype wire

[dv/sliding_window_median_filter_unit_test.sv]
`timescale 1ns / 1ps
module sliding_window_median_filter_unit_test
    import swmf_pkg::*;
();

    localparam int MAXW = 63;
    localparam int SW   = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BL_W-1:0]    cfg_data;
    logic               push;
    logic               full;
    logic [SW-1:0]      sample;
    logic               empty;
    logic               pop;
    logic [SW-1:0]      median_value;
    logic               block_end;

    typedef struct packed {
        logic [SW-1:0] median;
        logic          last;
    } median_item_t;

    // Predictor state
    logic [5:0]         pred_ws;
    logic [15:0]        pred_bl;
    logic signed [SW-1:0] hist [MAXW];
    int unsigned        seen;
    int unsigned        eff_win;

    median_item_t       median_q[$];
    int                 errors;
    int                 idle_cycles;
    int                 burst_left;
    int                 gap_left;

    sliding_window_median_filter_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full), .sample(sample),
        .empty(empty), .pop(pop),
        .median_value(median_value), .block_end(block_end)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Median of the window ending lead positions past the newest sample
    function automatic logic signed [SW-1:0] window_median(int unsigned lead);
        int signed v [MAXW];
        int signed x;
        int signed s;
        int a;
        for (int c = 0; c < eff_win; c++)
        begin
            x = 0;
            if (c >= lead && (c - lead) < MAXW)
                x = hist[c - lead];
            a = c;
            while (a > 0 && v[a-1] > x)
            begin
                v[a] = v[a-1];
                a--;
            end
            v[a] = x;
        end
        if (eff_win % 2 == 1)
            return v[eff_win/2];
        s = v[eff_win/2 - 1] + v[eff_win/2];
        return s >>> 1;
    endfunction

    // Expected medians caused by one accepted sample
    task automatic predict_medians(logic [SW-1:0] smp);
        int unsigned len;
        int unsigned half;
        int unsigned jmax;
        bit last;
        median_item_t it;
        len = (pred_bl == 0) ? 1 : pred_bl;
        if (seen == 0)
        begin
            for (int i = 0; i < MAXW; i++)
                hist[i] = '0;
            if (pred_ws < 1 || pred_ws > len || pred_ws > MAXW)
                eff_win = 1;
            else
                eff_win = pred_ws;
        end
        for (int i = MAXW - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = smp;
        half = eff_win / 2;
        last = (seen + 1 >= len);
        jmax = last ? half : 0;
        for (int j = 0; j <= jmax; j++)
        begin
            if (seen + j >= half)
            begin
                it.median = window_median(j);
                it.last   = last && (j == jmax);
                median_q.push_back(it);
            end
        end
        seen = last ? 0 : ((seen + 1) & 16'hFFFF);
    endtask

    // Send one sample; push stays high inside a burst and drops for a gap
    task automatic send_sample(logic [SW-1:0] smp);
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap_left > 0)
            begin
                push <= 1'b0;
                repeat (gap_left) @(negedge clk);
            end
        end
        burst_left--;
        push   <= 1'b1;
        sample <= smp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_medians(smp);
        @(negedge clk);
    endtask

    // Wait for every expected median, then let the pipe settle
    task automatic drain;
        push <= 1'b0;
        while (median_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WINDOW_SIZE)
            pred_ws = val[5:0];
        else if (idx == CFG_BLOCK_LENGTH)
            pred_bl = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [BL_W-1:0] ws, logic [BL_W-1:0] bl);
        drain();
        write_reg(CFG_WINDOW_SIZE, ws);
        write_reg(CFG_BLOCK_LENGTH, bl);
    endtask

    task automatic test_extremes;
        set_config(16'd5, 16'd12);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h1234);
    endtask

    task automatic test_fallbacks;
        // even window, zero window, window above block length, zero block length
        set_config(16'd4, 16'd6);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 16'h8001 : 16'h7FFE);
        set_config(16'd0, 16'd3);
        send_sample(16'h0010);
        send_sample(16'hFFF0);
        send_sample(16'h0003);
        set_config(16'd9, 16'd4);
        for (int i = 0; i < 4; i++)
            send_sample(SW'($urandom()));
        set_config(16'd2, 16'd0);
        send_sample(16'h0007);
        send_sample(16'hFFF9);
    endtask

    task automatic test_mid_block_changes;
        // block length lowered and window changed mid-block
        set_config(16'd7, 16'd20);
        for (int i = 0; i < 5; i++)
            send_sample(SW'($urandom()));
        set_config(16'd3, 16'd3);
        for (int i = 0; i < 7; i++)
            send_sample(SW'($urandom()));
    endtask

    task automatic test_random;
        int n;
        int bl;
        n = 0;
        while (n < 300)
        begin
            case ($urandom_range(0, 4))
                0: set_config(16'd63, 16'(63 + $urandom_range(0, 40)));
                1: set_config(16'($urandom_range(0, 63)), 16'($urandom_range(0, 12)));
                2: set_config(16'd1, 16'hFFFF);
                default: set_config(16'($urandom_range(1, 16)), 16'($urandom_range(4, 40)));
            endcase
            bl = (pred_bl == 0) ? 1 : pred_bl;
            if (bl > 120)
                bl = 60;
            for (int i = 0; i < bl * $urandom_range(1, 2); i++)
            begin
                send_sample(SW'($urandom_range(0, 3) == 0 ?
                    ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000) : $urandom()));
                n++;
            end
        end
        // leave registers at max window with a block length of 63
        set_config(16'd63, 16'd63);
        for (int i = 0; i < 63; i++)
            send_sample(SW'($urandom()));
    endtask

    // Result receiver: stall pattern plus checks
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin
        median_item_t exp_item;
        if (rst_n && pop && !empty)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t: unexpected median %h block_end %b", $time,
                    median_value, block_end);
                errors++;
            end
            else
            begin
                exp_item = median_q.pop_front();
                if (median_value !== exp_item.median)
                begin
                    $display("%0t: median_value expected %h actual %h", $time,
                        exp_item.median, median_value);
                    errors++;
                end
                if (block_end !== exp_item.last)
                begin
                    $display("%0t: block_end expected %b actual %b", $time,
                        exp_item.last, block_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        sample = '0;
        pop = 1'b0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        pred_ws = WS_RESET;
        pred_bl = BL_RESET;
        seen = 0;
        eff_win = 1;
        for (int i = 0; i < MAXW; i++)
            hist[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // a few samples at reset settings
        for (int i = 0; i < 5; i++)
            send_sample(SW'($urandom()));
        test_extremes();
        test_fallbacks();
        test_mid_block_changes();
        test_random();
        // flush the open block so every sample's results arrive
        set_config(16'd1, 16'd1);
        send_sample(16'h0000);
        drain();
        if (errors == 0 && median_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
